// ----- rtl/sm83alu_pkg.sv -----
// Shared types and constants for the SM83 ALU: operation codes,
// request/response payload structs, flag bit positions and DAA limits.
// No dependencies.
`timescale 1ns / 1ps

package sm83alu_pkg;

    localparam int unsigned CmdWidth  = 6;
    localparam int unsigned WordWidth = 16;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned FlagWidth = 4;

    // flag bit positions
    localparam int unsigned FlagZ = 3;
    localparam int unsigned FlagN = 2;
    localparam int unsigned FlagH = 1;
    localparam int unsigned FlagC = 0;

    // decimal adjust limits and corrections
    localparam logic [7:0] DaaHiLimit = 8'h99;
    localparam logic [3:0] DaaLoLimit = 4'h9;
    localparam logic [7:0] DaaHiAdj   = 8'h60;
    localparam logic [7:0] DaaLoAdj   = 8'h06;

    typedef enum logic [CmdWidth-1:0] {
        OP_ADD    = 6'd0,
        OP_ADC    = 6'd1,
        OP_SUB    = 6'd2,
        OP_SBC    = 6'd3,
        OP_AND    = 6'd4,
        OP_XOR    = 6'd5,
        OP_OR     = 6'd6,
        OP_CP     = 6'd7,
        OP_INC8   = 6'd8,
        OP_DEC8   = 6'd9,
        OP_DAA    = 6'd10,
        OP_CPL    = 6'd11,
        OP_SCF    = 6'd12,
        OP_CCF    = 6'd13,
        OP_RLCA   = 6'd14,
        OP_RLA    = 6'd15,
        OP_RRCA   = 6'd16,
        OP_RRA    = 6'd17,
        OP_RLC    = 6'd18,
        OP_RRC    = 6'd19,
        OP_RL     = 6'd20,
        OP_RR     = 6'd21,
        OP_SLA    = 6'd22,
        OP_SRA    = 6'd23,
        OP_SWAP   = 6'd24,
        OP_SRL    = 6'd25,
        OP_BIT    = 6'd26,
        OP_RES    = 6'd27,
        OP_SET    = 6'd28,
        OP_ADD16  = 6'd29,
        OP_ADDSP  = 6'd30,
        OP_INC16  = 6'd31,
        OP_DEC16  = 6'd32
    } t_alu_op;

    typedef struct packed {
        logic [CmdWidth-1:0]  cmd;
        logic [WordWidth-1:0] operand_a;
        logic [WordWidth-1:0] operand_b;
        logic [2:0]           bit_select;
        logic [FlagWidth-1:0] flags_in;
    } t_alu_req;

    typedef struct packed {
        logic [WordWidth-1:0] result_value;
        logic [FlagWidth-1:0] flags_out;
    } t_alu_rsp;

endpackage

// ----- rtl/sm83_alu_with_flags.sv -----
// SM83 ALU top level: request register, combinational datapath, result register.
// Path: accepted request into the request register, through the core, into the result register.
// Throughput: one request per cycle when not stalled; an empty request stage also fills during a stall.
// Reset (i_rst_n low, synchronous) empties both stages; payload registers keep data.
// Depends on sm83alu_pkg and sm83alu_core.
`timescale 1ns / 1ps

module sm83_alu_with_flags
    import sm83alu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_alu_req i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_alu_rsp o_out_rsp
);

    logic     r_in_vld;
    logic     n_in_vld;
    t_alu_req r_in_req;
    logic     r_out_vld;
    logic     n_out_vld;
    t_alu_rsp r_out_rsp;
    t_alu_rsp core_rsp;
    logic     out_en;
    logic     in_take;

    // result stage moves when empty or drained this cycle
    assign out_en     = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || out_en;
    assign in_take    = i_in_valid && o_in_ready;

    assign n_in_vld  = in_take ? 1'b1 : (out_en ? 1'b0 : r_in_vld);
    assign n_out_vld = out_en ? r_in_vld : r_out_vld;

    sm83alu_core u_core (
        .i_req (r_in_req),
        .o_rsp (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req <= i_in_req;
        end
        if (out_en && r_in_vld) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out_rsp;

    // stall only when both stages hold requests and the consumer holds off
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled without a full pipeline");

    // an accepted request lands in the request register
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_vld)
        else $error("accepted request lost");

    // a request in flight reaches the result register when it advances
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_en) |=> o_out_valid)
        else $error("request dropped between stages");

    // result register holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> (r_out_vld && $stable(r_out_rsp)))
        else $error("stalled result changed");

endmodule

// ----- rtl/sm83alu_core.sv -----
// Combinational datapath of the SM83 ALU: decodes one request and forms
// the result word and new flags. Depends on sm83alu_pkg.
`timescale 1ns / 1ps

module sm83alu_core
    import sm83alu_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic [3:0]  f;
    logic        cin;
    logic        carry_t;
    logic [8:0]  add9;
    logic [4:0]  add_lo;
    logic [8:0]  sub9;
    logic [4:0]  sub_lo;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  daa_adj;
    logic        daa_c;
    logic [7:0]  daa_r;
    logic [7:0]  bit_mask;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [15:0] sp_sum;
    logic [8:0]  sp_lo8;
    logic [4:0]  sp_lo4;

    assign a   = i_req.operand_a[7:0];
    assign b   = i_req.operand_b[7:0];
    assign f   = i_req.flags_in;
    assign cin = f[FlagC];

    // carry/borrow in only for adc and sbc
    assign carry_t = ((i_req.cmd == OP_ADC) || (i_req.cmd == OP_SBC)) ? cin : 1'b0;

    assign add9   = {1'b0, a} + {1'b0, b} + {8'd0, carry_t};
    assign add_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_t};
    assign sub9   = {1'b0, a} - {1'b0, b} - {8'd0, carry_t};
    assign sub_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_t};
    assign inc8   = b + 8'd1;
    assign dec8   = b - 8'd1;

    always_comb begin
        daa_adj = 8'd0;
        daa_c   = 1'b0;
        if (f[FlagH] || (!f[FlagN] && (a[3:0] > DaaLoLimit))) begin
            daa_adj = DaaLoAdj;
        end
        if (cin || (!f[FlagN] && (a > DaaHiLimit))) begin
            daa_adj = daa_adj | DaaHiAdj;
            daa_c   = 1'b1;
        end
        daa_r = f[FlagN] ? (a - daa_adj) : (a + daa_adj);
    end

    assign bit_mask = 8'd1 << i_req.bit_select;

    assign add17  = {1'b0, i_req.operand_a} + {1'b0, i_req.operand_b};
    assign add13  = {1'b0, i_req.operand_a[11:0]} + {1'b0, i_req.operand_b[11:0]};
    assign sp_sum = i_req.operand_a + {{8{b[7]}}, b};
    assign sp_lo8 = {1'b0, i_req.operand_a[7:0]} + {1'b0, b};
    assign sp_lo4 = {1'b0, i_req.operand_a[3:0]} + {1'b0, b[3:0]};

    always_comb begin
        logic [7:0] r8;
        logic       c;
        r8 = 8'd0;
        c  = 1'b0;
        o_rsp.result_value = i_req.operand_a;
        o_rsp.flags_out    = f;
        unique case (i_req.cmd)
            OP_ADD, OP_ADC: begin
                r8 = add9[7:0];
                o_rsp.result_value = {8'd0, r8};
                o_rsp.flags_out    = {r8 == 8'd0, 1'b0, add_lo[4], add9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                r8 = sub9[7:0];
                o_rsp.result_value = (i_req.cmd == OP_CP) ? {8'd0, a} : {8'd0, r8};
                o_rsp.flags_out    = {r8 == 8'd0, 1'b1, sub_lo[4], sub9[8]};
            end
            OP_AND: begin
                r8 = a & b;
                o_rsp.result_value = {8'd0, r8};
                o_rsp.flags_out    = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                r8 = a ^ b;
                o_rsp.result_value = {8'd0, r8};
                o_rsp.flags_out    = {r8 == 8'd0, 3'b000};
            end
            OP_OR: begin
                r8 = a | b;
                o_rsp.result_value = {8'd0, r8};
                o_rsp.flags_out    = {r8 == 8'd0, 3'b000};
            end
            OP_INC8: begin
                o_rsp.result_value = {8'd0, inc8};
                o_rsp.flags_out    = {inc8 == 8'd0, 1'b0, inc8[3:0] == 4'h0, cin};
            end
            OP_DEC8: begin
                o_rsp.result_value = {8'd0, dec8};
                o_rsp.flags_out    = {dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hF, cin};
            end
            OP_DAA: begin
                o_rsp.result_value = {8'd0, daa_r};
                o_rsp.flags_out    = {daa_r == 8'd0, f[FlagN], 1'b0, daa_c};
            end
            OP_CPL: begin
                o_rsp.result_value = {8'd0, ~a};
                o_rsp.flags_out    = {f[FlagZ], 1'b1, 1'b1, cin};
            end
            OP_SCF: begin
                o_rsp.result_value = {8'd0, a};
                o_rsp.flags_out    = {f[FlagZ], 3'b001};
            end
            OP_CCF: begin
                o_rsp.result_value = {8'd0, a};
                o_rsp.flags_out    = {f[FlagZ], 2'b00, ~cin};
            end
            OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
                case (i_req.cmd)
                    OP_RLCA: begin c = a[7]; r8 = {a[6:0], a[7]}; end
                    OP_RLA:  begin c = a[7]; r8 = {a[6:0], cin}; end
                    OP_RRCA: begin c = a[0]; r8 = {a[0], a[7:1]}; end
                    default: begin c = a[0]; r8 = {cin, a[7:1]}; end
                endcase
                o_rsp.result_value = {8'd0, r8};
                o_rsp.flags_out    = {3'b000, c};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
                case (i_req.cmd)
                    OP_RLC:  begin c = b[7]; r8 = {b[6:0], b[7]}; end
                    OP_RRC:  begin c = b[0]; r8 = {b[0], b[7:1]}; end
                    OP_RL:   begin c = b[7]; r8 = {b[6:0], cin}; end
                    OP_RR:   begin c = b[0]; r8 = {cin, b[7:1]}; end
                    OP_SLA:  begin c = b[7]; r8 = {b[6:0], 1'b0}; end
                    OP_SRA:  begin c = b[0]; r8 = {b[7], b[7:1]}; end
                    OP_SWAP: begin c = 1'b0; r8 = {b[3:0], b[7:4]}; end
                    default: begin c = b[0]; r8 = {1'b0, b[7:1]}; end
                endcase
                o_rsp.result_value = {8'd0, r8};
                o_rsp.flags_out    = {r8 == 8'd0, 2'b00, c};
            end
            OP_BIT: begin
                o_rsp.result_value = {8'd0, b};
                o_rsp.flags_out    = {(b & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
            end
            OP_RES: begin
                o_rsp.result_value = {8'd0, b & ~bit_mask};
            end
            OP_SET: begin
                o_rsp.result_value = {8'd0, b | bit_mask};
            end
            OP_ADD16: begin
                o_rsp.result_value = add17[15:0];
                o_rsp.flags_out    = {f[FlagZ], 1'b0, add13[12], add17[16]};
            end
            OP_ADDSP: begin
                o_rsp.result_value = sp_sum;
                o_rsp.flags_out    = {2'b00, sp_lo4[4], sp_lo8[8]};
            end
            OP_INC16: begin
                o_rsp.result_value = i_req.operand_a + 16'd1;
            end
            OP_DEC16: begin
                o_rsp.result_value = i_req.operand_a - 16'd1;
            end
            default: begin
                // unknown code: pass operand_a and flags through
                o_rsp.result_value = i_req.operand_a;
            end
        endcase
    end

endmodule
